@@ hw/rtl/urist_pkg.sv @@
// urist_pkg: types, codes and character helpers for the uri stream tokenizer
// no dependencies; imported by every module of the block

package urist_pkg;

    // parse phases
    localparam logic [3:0] PH_SCHEME = 4'd0;
    localparam logic [3:0] PH_SLASH1 = 4'd1;
    localparam logic [3:0] PH_SLASH2 = 4'd2;
    localparam logic [3:0] PH_NAME1  = 4'd3;
    localparam logic [3:0] PH_NAME2  = 4'd4;
    localparam logic [3:0] PH_PORT   = 4'd5;
    localparam logic [3:0] PH_PATH   = 4'd6;
    localparam logic [3:0] PH_QNAME  = 4'd7;
    localparam logic [3:0] PH_QVAL   = 4'd8;
    localparam logic [3:0] PH_ERR    = 4'd9;

    // field kinds
    localparam logic [2:0] FK_SCHEME = 3'd0;
    localparam logic [2:0] FK_NAME1  = 3'd1;
    localparam logic [2:0] FK_HOST   = 3'd2;
    localparam logic [2:0] FK_PATH   = 3'd3;
    localparam logic [2:0] FK_QNAME  = 3'd4;
    localparam logic [2:0] FK_QVAL   = 3'd5;

    // marks
    localparam logic [1:0] MK_NONE   = 2'd0;
    localparam logic [1:0] MK_USER   = 2'd1;
    localparam logic [1:0] MK_VALUE  = 2'd2;
    localparam logic [1:0] MK_PAIR   = 2'd3;

    // escape stages
    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_HIGH  = 2'd1;
    localparam logic [1:0] ESC_LOW   = 2'd2;

    // configuration
    localparam logic [15:0] RESET_DEFAULT_PORT = 16'd50000;
    localparam logic [15:0] PORT_MAX           = 16'hFFFF;
    localparam logic [2:0]  REG_DEFAULT_PORT   = 3'd0;

    // characters
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    // one result beat
    typedef struct packed {
        logic        char_valid;
        logic [7:0]  char_out;
        logic [2:0]  field_kind;
        logic [1:0]  mark;
        logic        done_res;
        logic        parse_error;
        logic [15:0] port;
    } t_result;

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        is_alnum = is_digit(b) || ((b >= 8'h61) && (b <= 8'h7A))
                   || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_name(input logic [7:0] b);
        is_name = is_alnum(b) || (b == CH_DOT) || (b == CH_UNDER);
    endfunction

    // non-hex characters count as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [7:0] v;
        v = 8'd0;
        if (is_digit(b)) begin
            v = b - 8'h30;
        end else if ((b >= 8'h61) && (b <= 8'h66)) begin
            v = b - 8'h57;
        end else if ((b >= 8'h41) && (b <= 8'h46)) begin
            v = b - 8'h37;
        end
        hex_nibble = v[3:0];
    endfunction

    // letters of the scheme that needs no port
    function automatic logic [7:0] shm_char(input logic [1:0] idx);
        case (idx)
            2'd0:    shm_char = 8'h73;
            2'd1:    shm_char = 8'h68;
            2'd2:    shm_char = 8'h6D;
            default: shm_char = 8'h00;
        endcase
    endfunction

endpackage

@@ hw/rtl/urist_apb.sv @@
// urist_apb: configuration register file behind an apb-style port
// depends on urist_pkg

module urist_apb (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_default_port
);
    import urist_pkg::*;

    logic [15:0] r_default_port;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == REG_DEFAULT_PORT[2]);

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_port <= RESET_DEFAULT_PORT;
        end else if (w_wr) begin
            r_default_port <= pwdata[15:0];
        end
    end

    // read back
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_DEFAULT_PORT[2]) begin
            prdata = {16'd0, r_default_port};
        end
    end

    assign o_default_port = r_default_port;

endmodule

@@ hw/rtl/urist_parser.sv @@
// urist_parser: parse state registers and the per-byte step logic
// depends on urist_pkg

module urist_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    input  logic [15:0]        i_default_port,
    output urist_pkg::t_result o_res
);
    import urist_pkg::*;

    logic [3:0]  r_phase,   n_phase;
    logic [1:0]  r_match,   n_match;
    logic        r_sbad,    n_sbad;
    logic [15:0] r_port,    n_port;
    logic        r_given,   n_given;
    logic [1:0]  r_esc,     n_esc;
    logic [3:0]  r_hi,      n_hi;
    logic        r_err,     n_err;

    logic        w_cv;
    logic [7:0]  w_co;
    logic [2:0]  w_kind;
    logic [1:0]  w_mk;
    logic        w_bad;
    logic [19:0] w_prod;
    logic [15:0] w_port_out;

    // port accumulate: acc*10 + digit, saturating
    assign w_prod = {1'b0, r_port, 3'b000} + {3'b000, r_port, 1'b0}
                    + {16'd0, i_byte[3:0]};

    // step for one byte
    always_comb begin
        n_phase = r_phase;
        n_match = r_match;
        n_sbad  = r_sbad;
        n_port  = r_port;
        n_given = r_given;
        n_esc   = r_esc;
        n_hi    = r_hi;
        n_err   = r_err;
        w_cv    = 1'b0;
        w_co    = 8'd0;
        w_kind  = FK_SCHEME;
        w_mk    = MK_NONE;
        w_bad   = 1'b0;
        case (r_phase)
            PH_SCHEME: begin
                if (is_alnum(i_byte)) begin
                    w_cv = 1'b1;
                    w_co = i_byte;
                    if (!r_sbad && (r_match != 2'd3) && (i_byte == shm_char(r_match))) begin
                        n_match = r_match + 2'd1;
                    end else begin
                        n_sbad = 1'b1;
                    end
                    w_bad = i_last;
                end else if (i_byte == CH_COLON) begin
                    n_phase = PH_SLASH1;
                    w_bad   = i_last;
                end else begin
                    w_bad = 1'b1;
                end
            end
            PH_SLASH1: begin
                if (i_byte == CH_SLASH) begin
                    n_phase = PH_SLASH2;
                    w_bad   = i_last;
                end else begin
                    w_bad = 1'b1;
                end
            end
            PH_SLASH2: begin
                if (i_byte == CH_SLASH) begin
                    n_phase = PH_NAME1;
                end else begin
                    w_bad = 1'b1;
                end
            end
            PH_NAME1, PH_NAME2: begin
                if (is_name(i_byte)) begin
                    w_cv   = 1'b1;
                    w_co   = i_byte;
                    w_kind = (r_phase == PH_NAME1) ? FK_NAME1 : FK_HOST;
                    w_bad  = (r_phase == PH_NAME2) && i_last;
                end else if ((i_byte == CH_AT) && (r_phase == PH_NAME1)) begin
                    w_mk    = MK_USER;
                    n_phase = PH_NAME2;
                    w_bad   = i_last;
                end else if (i_byte == CH_COLON) begin
                    n_given = 1'b1;
                    n_phase = PH_PORT;
                    w_bad   = i_last;
                end else if (i_byte == CH_SLASH) begin
                    n_phase = PH_PATH;
                end else begin
                    w_bad = 1'b1;
                end
            end
            PH_PORT: begin
                if (is_digit(i_byte)) begin
                    n_port = (w_prod > {4'd0, PORT_MAX}) ? PORT_MAX : w_prod[15:0];
                    w_bad  = i_last;
                end else if (i_byte == CH_SLASH) begin
                    n_phase = PH_PATH;
                end else begin
                    w_bad = 1'b1;
                end
            end
            PH_PATH: begin
                if (i_byte == CH_QUEST) begin
                    n_phase = PH_QNAME;
                    w_bad   = i_last;
                end else begin
                    w_cv   = 1'b1;
                    w_co   = i_byte;
                    w_kind = FK_PATH;
                end
            end
            PH_QNAME, PH_QVAL: begin
                w_kind = (r_phase == PH_QNAME) ? FK_QNAME : FK_QVAL;
                if (r_esc == ESC_HIGH) begin
                    n_hi  = hex_nibble(i_byte);
                    n_esc = ESC_LOW;
                    w_bad = i_last;
                end else if (r_esc == ESC_LOW) begin
                    w_cv  = 1'b1;
                    w_co  = {r_hi, hex_nibble(i_byte)};
                    n_esc = ESC_NONE;
                    w_bad = i_last && (r_phase == PH_QNAME);
                end else if (i_byte == CH_PERCENT) begin
                    n_esc = ESC_HIGH;
                    w_bad = i_last;
                end else if ((r_phase == PH_QNAME) && (i_byte == CH_EQUALS)) begin
                    w_mk    = MK_VALUE;
                    n_phase = PH_QVAL;
                end else if ((r_phase == PH_QVAL) && (i_byte == CH_AMP)) begin
                    w_mk    = MK_PAIR;
                    n_phase = PH_QNAME;
                    w_bad   = i_last;
                end else begin
                    w_cv  = 1'b1;
                    w_co  = (i_byte == CH_PLUS) ? CH_SPACE : i_byte;
                    w_bad = i_last && (r_phase == PH_QNAME);
                end
            end
            default: begin
            end
        endcase
        if (w_bad) begin
            n_err   = 1'b1;
            n_phase = PH_ERR;
        end
    end

    // port reported on the final byte
    always_comb begin
        w_port_out = 16'd0;
        if (i_last && !n_err) begin
            if (n_given) begin
                w_port_out = n_port;
            end else if (!n_sbad && (n_match == 2'd3)) begin
                w_port_out = 16'd0;
            end else begin
                w_port_out = i_default_port;
            end
        end
    end

    // result beat
    always_comb begin
        o_res.char_valid  = w_cv;
        o_res.char_out    = w_co;
        o_res.field_kind  = w_cv ? w_kind : FK_SCHEME;
        o_res.mark        = w_mk;
        o_res.done_res    = i_last;
        o_res.parse_error = i_last && n_err;
        o_res.port        = w_port_out;
    end

    // state update, cleared after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase <= PH_SCHEME;
            r_match <= 2'd0;
            r_sbad  <= 1'b0;
            r_port  <= 16'd0;
            r_given <= 1'b0;
            r_esc   <= ESC_NONE;
            r_hi    <= 4'd0;
            r_err   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_match <= n_match;
            r_sbad  <= n_sbad;
            r_port  <= n_port;
            r_given <= n_given;
            r_esc   <= n_esc;
            r_hi    <= n_hi;
            r_err   <= n_err;
        end
    end

endmodule

@@ hw/rtl/uri_stream_tokenizer.sv @@
// uri_stream_tokenizer: top level with input register, parser and result register
// depends on urist_pkg, urist_apb, urist_parser

// One URI byte enters per beat on the slave stream (tlast on its final byte) and one
// result beat leaves per input byte when the master side is ready. Throughput is one
// byte per cycle while the master is ready: the whole parse step sits between the input
// register and the result register, and parse state is updated in the same cycle.
// Each result carries the field character and its kind, delimiter marks, and on the
// final byte done (tlast), the error flag and the port. The default port register
// sits at address 0 of the apb port and may be written only while the block is idle.

module uri_stream_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] char_out, [9:8] mark, [10] parse_error,
                                        // [26:11] port, [31:27] zero
    output logic [3:0]  m_axis_tuser,   // [0] char_valid, [3:1] field_kind
    output logic        m_axis_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import urist_pkg::*;

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_vld;
    t_result     r_out;
    t_result     w_res;
    logic        w_adv;
    logic [15:0] w_default_port;

    // step when the result register is free or being drained
    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;

    urist_apb u_apb (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_default_port (w_default_port)
    );

    urist_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_adv),
        .i_byte         (r_in_byte),
        .i_last         (r_in_last),
        .i_default_port (w_default_port),
        .o_res          (w_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    // master beat packing
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_out.port, r_out.parse_error, r_out.mark, r_out.char_out};
    assign m_axis_tuser  = {r_out.field_kind, r_out.char_valid};
    assign m_axis_tlast  = r_out.done_res;

endmodule
